### hdl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// shared types, codes and defaults for the indexed list store
// ----------------------------------------------------------------------------
package lis_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [2:0] KIND_READ   = 3'd0;
    localparam logic [2:0] KIND_FRONT  = 3'd1;
    localparam logic [2:0] KIND_APPEND = 3'd2;
    localparam logic [2:0] KIND_INSERT = 3'd3;
    localparam logic [2:0] KIND_DELETE = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]         kind;
        logic [6:0]         position;
        logic signed [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [6:0]         length;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_DRAIN,
        S_PUT
    } state_t;

endpackage

### hdl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// ordered list of signed 32-bit words with read, insert and delete by index
// ----------------------------------------------------------------------------
// a read goes through S_READ; an append or insert at the end goes to S_PUT;
//   other inserts shift the words from p up one slot (S_SHIFT, S_DRAIN) before S_PUT;
//   a delete shifts the words above p down, or only shortens the list for the last
//   word; one request at a time, busy is high until the result strobe
// reset clears the length; the store itself is not cleared
// the result strobe lasts one cycle and cannot be stalled by the receiver
module indexed_list_store
    import lis_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    lis_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    lis_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

### hdl/lis_mem.sv
// ----------------------------------------------------------------------------
// lis_mem
// element storage: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module lis_mem
    import lis_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] store_reg [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= store_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/lis_ctrl.sv
// ----------------------------------------------------------------------------
// lis_ctrl
// request decode, shift sequencer and result register for the list store
// ----------------------------------------------------------------------------
module lis_ctrl
    import lis_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  req_t          req,
    output logic          busy,
    output logic          done,
    output rsp_t          rsp,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [31:0]   mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  logic [31:0]   mem_rdata
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    state_t        state_reg,   state_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [AW-1:0] src_reg,     src_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic          wr_pend_reg, wr_pend_next;
    logic          ins_reg,     ins_next;
    logic [AW-1:0] put_reg,     put_next;
    logic [31:0]   value_reg,   value_next;
    logic          done_reg,    done_next;
    rsp_t          rsp_reg,     rsp_next;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] ins_pos;
    logic            full;
    logic            last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        wr_addr_reg <= wr_addr_next;
        ins_reg     <= ins_next;
        put_reg     <= put_next;
        value_reg   <= value_next;
        rsp_reg     <= rsp_next;
    end

    assign pos_ext = CMPW'(req.position);
    assign cnt_ext = CMPW'(count_reg);
    assign full    = (count_reg >= CW'(CAPACITY));
    assign last    = ins_reg ? (src_reg == put_reg) : (src_reg == AW'(count_reg - 1'b1));

    always_comb
    begin
        case (req.kind)
            KIND_FRONT:  ins_pos = '0;
            KIND_APPEND: ins_pos = cnt_ext;
            default:     ins_pos = pos_ext;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        src_next     = src_reg;
        wr_addr_next = wr_addr_reg;
        wr_pend_next = wr_pend_reg;
        ins_next     = ins_reg;
        put_next     = put_reg;
        value_next   = value_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        mem_we       = 1'b0;
        mem_waddr    = wr_addr_reg;
        mem_wdata    = mem_rdata;
        mem_raddr    = (state_reg == S_SHIFT) ? src_reg : AW'(req.position);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rsp_next.read_value = ALL_ONES;
                    rsp_next.status     = ST_DONE;
                    value_next          = req.item_value;
                    wr_pend_next        = 1'b0;
                    case (req.kind)
                        KIND_READ:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                rsp_next.status = ST_RANGE;
                                done_next       = 1'b1;
                            end
                        end
                        KIND_FRONT, KIND_APPEND, KIND_INSERT:
                        begin
                            if (ins_pos > cnt_ext)
                            begin
                                rsp_next.status = ST_RANGE;
                                done_next       = 1'b1;
                            end
                            else if (full)
                            begin
                                rsp_next.status = ST_FULL;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                ins_next = 1'b1;
                                put_next = AW'(ins_pos);
                                src_next = AW'(count_reg - 1'b1);
                                // nothing to move when the slot is at the end
                                state_next = (ins_pos == cnt_ext) ? S_PUT : S_SHIFT;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                ins_next = 1'b0;
                                src_next = AW'(pos_ext + 1'b1);
                                if (pos_ext == cnt_ext - 1'b1)
                                begin
                                    count_next = count_reg - 1'b1;
                                    done_next  = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_SHIFT;
                                end
                            end
                            else
                            begin
                                rsp_next.status = ST_RANGE;
                                done_next       = 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = ST_RANGE;
                            done_next       = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rsp_next.read_value = mem_rdata;
                done_next           = 1'b1;
                state_next          = S_IDLE;
            end
            S_SHIFT:
            begin
                // word read last cycle lands one slot over this cycle
                mem_we       = wr_pend_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = ins_reg ? (src_reg + 1'b1) : (src_reg - 1'b1);
                src_next     = ins_reg ? (src_reg - 1'b1) : (src_reg + 1'b1);
                if (last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                mem_we       = 1'b1;
                wr_pend_next = 1'b0;
                if (ins_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = put_reg;
                mem_wdata  = value_reg;
                count_next = count_reg + 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            rsp_next.length = 7'(count_next);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result shown while a request is still at work");

    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && wr_pend_reg) |-> (wr_addr_reg != src_reg))
        else $error("shift writes the entry it reads");

    a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (count_next != count_reg) |=> done_reg)
        else $error("length changed without a result");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> busy)
        else $error("store written while idle");

endmodule
